FILE: design/serial_handshake_rumble_responder_defines.svh
// ----------------------------------------------------------------------------
// Serial handshake rumble responder: assertion macros
// Shared property wrappers, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SERIAL_HANDSHAKE_RUMBLE_RESPONDER_DEFINES_SVH
`define SERIAL_HANDSHAKE_RUMBLE_RESPONDER_DEFINES_SVH

// Same-cycle implication.
`define SHRR_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SHRR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/shrr_pkg.sv
// ----------------------------------------------------------------------------
// Serial handshake rumble responder package
// Stage codes, protocol words and the ID string fragments.
// ----------------------------------------------------------------------------
package shrr_pkg;

	// Protocol stages.
	typedef enum logic [2:0] {
		STAGE_SHAKE  = 3'd0,
		STAGE_MAGIC1 = 3'd1,
		STAGE_MAGIC2 = 3'd2,
		STAGE_RUMBLE = 3'd3,
		STAGE_FINAL  = 3'd4
	} stage_t;

	// Rumble command codes.
	typedef enum logic [1:0] {
		MODE_STOP  = 2'd0,
		MODE_START = 2'd1,
		MODE_HARD  = 2'd2
	} rumble_t;

	localparam logic [31:0] WordPoll  = 32'h3000_0003;
	localparam logic [15:0] LowStart  = 16'h8002;
	localparam logic [31:0] MagicOne  = 32'h1000_0010;
	localparam logic [31:0] MagicTwo  = 32'h2000_0013;
	localparam logic [31:0] CmdStop   = 32'h4000_0004;
	localparam logic [31:0] CmdStart  = 32'h4000_0026;
	localparam logic [31:0] CmdHard   = 32'h4000_0015;
	localparam logic [15:0] StringEnd = 16'h8000;
	localparam logic [2:0]  LastFrag  = 3'd3;

	// ID string, two characters per word, first character in the low byte.
	function automatic logic [15:0] id_fragment(input logic [1:0] idx);
		logic [15:0] frag;
		case (idx)
			2'd0:    frag = 16'h494E;
			2'd1:    frag = 16'h544E;
			2'd2:    frag = 16'h4E45;
			default: frag = 16'h4F44;
		endcase
		return frag;
	endfunction

	// Reply word for a rumble poll; the unused code answers as stop.
	function automatic logic [31:0] command_word(input logic [1:0] mode);
		logic [31:0] word;
		case (mode)
			MODE_START: word = CmdStart;
			MODE_HARD:  word = CmdHard;
			default:    word = CmdStop;
		endcase
		return word;
	endfunction

endpackage

FILE: design/serial_handshake_rumble_responder.sv
// ----------------------------------------------------------------------------
// Serial handshake rumble responder
// Slave side of a 32-bit serial handshake that answers with the next word.
// ----------------------------------------------------------------------------
// Usage:
// Each received serial word enters on the s_ channel together with the
// current rumble command; the m_ channel returns the word to load for the
// next transfer. A word received in the finalize stage clears the protocol
// state and returns nothing.
// Path: an accepted word lands in the input register, is worked out against
// the protocol state combinationally and reaches m_tdata via the result register.
// Throughput: one word per cycle while replies are taken; the protocol state
// is updated by a single combinational pass between the input register and
// the result register.
// Reset: arst_n clears the stage, the string index and the last reply
// halves, and empties both registers.
// Stall: while m_tready is low a finished reply holds in the result
// register and one more word is still taken into the input register;
// s_tready then drops until the reply is taken, unless that word
// produces no reply.
// ----------------------------------------------------------------------------
module serial_handshake_rumble_responder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [31:0] rx_word, [33:32] rumble_mode, [39:34] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // [31:0] tx_word
);

	// Input register.
	logic        valid_s1;
	logic [31:0] rx_word_s1;
	logic [1:0]  rumble_mode_s1;

	// Protocol state.
	shrr_pkg::stage_t stage_q, stage_next;
	logic [2:0]  index_q, index_next;
	logic [15:0] last_upper_q, last_upper_next;
	logic [15:0] last_lower_q, last_lower_next;

	// Result register.
	logic        out_valid_q;
	logic [31:0] tx_word_q;

	// Working signals.
	logic [15:0] rx_low, rx_high;
	logic [2:0]  index_hold;
	logic [31:0] tx_word;
	logic        has_result;
	logic        advance;

	assign rx_low  = rx_word_s1[15:0];
	assign rx_high = rx_word_s1[31:16];

	// The input word moves on when its reply has room or it yields none.
	assign advance  = valid_s1 && (!out_valid_q || m_tready || !has_result);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = tx_word_q;

	// Next stage.
	always_comb begin
		case (stage_q)
			shrr_pkg::STAGE_SHAKE: begin
				stage_next = (rx_low == shrr_pkg::LowStart) ?
					shrr_pkg::STAGE_MAGIC1 : shrr_pkg::STAGE_SHAKE;
			end
			shrr_pkg::STAGE_MAGIC1: begin
				stage_next = (rx_word_s1 == shrr_pkg::MagicOne) ?
					shrr_pkg::STAGE_MAGIC2 : shrr_pkg::STAGE_FINAL;
			end
			shrr_pkg::STAGE_MAGIC2: begin
				stage_next = (rx_word_s1 == shrr_pkg::MagicTwo) ?
					shrr_pkg::STAGE_RUMBLE : shrr_pkg::STAGE_FINAL;
			end
			shrr_pkg::STAGE_RUMBLE: begin
				stage_next = (rx_word_s1 == shrr_pkg::WordPoll) ?
					shrr_pkg::STAGE_RUMBLE : shrr_pkg::STAGE_FINAL;
			end
			default: begin
				stage_next = shrr_pkg::STAGE_SHAKE;
			end
		endcase
	end

	// Reply word and handshake bookkeeping.
	always_comb begin
		index_next      = index_q;
		last_upper_next = last_upper_q;
		last_lower_next = last_lower_q;
		tx_word         = '0;
		has_result      = 1'b1;
		index_hold      = (rx_high != last_lower_q) ? 3'd0 : index_q;
		case (stage_q)
			shrr_pkg::STAGE_SHAKE: begin
				if (rx_low == shrr_pkg::LowStart) begin
					tx_word = shrr_pkg::MagicOne;
				end else begin
					// Advance when the partner echoed the inverse of our last reply.
					if (index_hold <= shrr_pkg::LastFrag &&
					    rx_word_s1 == ~{last_upper_q, last_lower_q}) begin
						index_next = index_hold + 3'd1;
					end else begin
						index_next = index_hold;
					end
					last_upper_next = (index_next > shrr_pkg::LastFrag) ?
						shrr_pkg::StringEnd : shrr_pkg::id_fragment(index_next[1:0]);
					last_lower_next = ~rx_low;
					tx_word         = {last_upper_next, last_lower_next};
				end
			end
			shrr_pkg::STAGE_MAGIC1: begin
				if (rx_word_s1 == shrr_pkg::MagicOne) begin
					tx_word = shrr_pkg::MagicTwo;
				end
			end
			shrr_pkg::STAGE_MAGIC2: begin
				if (rx_word_s1 == shrr_pkg::MagicTwo) begin
					tx_word = shrr_pkg::CmdStop;
				end
			end
			shrr_pkg::STAGE_RUMBLE: begin
				if (rx_word_s1 == shrr_pkg::WordPoll) begin
					tx_word = shrr_pkg::command_word(rumble_mode_s1);
				end
			end
			default: begin
				// Finalize: clear everything and send nothing.
				index_next      = '0;
				last_upper_next = '0;
				last_lower_next = '0;
				has_result      = 1'b0;
			end
		endcase
	end

	// Control and protocol state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			out_valid_q  <= 1'b0;
			stage_q      <= shrr_pkg::STAGE_SHAKE;
			index_q      <= '0;
			last_upper_q <= '0;
			last_lower_q <= '0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (advance) begin
				stage_q      <= stage_next;
				index_q      <= index_next;
				last_upper_q <= last_upper_next;
				last_lower_q <= last_lower_next;
				if (has_result) begin
					out_valid_q <= 1'b1;
				end
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			rx_word_s1     <= s_tdata[31:0];
			rumble_mode_s1 <= s_tdata[33:32];
		end
		if (advance && has_result) begin
			tx_word_q <= tx_word;
		end
	end

endmodule

FILE: design/shrr_checker.sv
// ----------------------------------------------------------------------------
// Serial handshake rumble responder checker
// Port-level assertions on the stream channels, bound to the top level.
// ----------------------------------------------------------------------------
`include "serial_handshake_rumble_responder_defines.svh"

module shrr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	// A stalled reply word holds its value.
	`SHRR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "reply word changed while stalled")

	// A reply word is withdrawn only after it was taken.
	`SHRR_ASSERT_IMPLY(a_out_drop, $fell(m_tvalid), $past(m_tready), "reply word dropped without transfer")

	// With an empty result register the input side never stalls.
	`SHRR_ASSERT_IMPLY(a_in_free, !m_tvalid, s_tready, "input stalled with empty result register")

	// A receiver that takes the reply never backs up the input side.
	`SHRR_ASSERT_IMPLY(a_in_flow, m_tready, s_tready, "input stalled while receiver is ready")

endmodule

bind serial_handshake_rumble_responder shrr_checker u_shrr_checker (.*);

FILE: dv/serial_handshake_rumble_responder_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Serial handshake rumble responder testbench
// Sends received words through the s_ channel and checks every reply word
// against a local model of the handshake, magic word and rumble stages.
// Both channels idle at random, apart from one steady stretch.
// ----------------------------------------------------------------------------
module serial_handshake_rumble_responder_test;

	localparam int WatchdogLimit = 2000;
	localparam int DrainCycles   = 12;
	localparam int IdlePct       = 18;
	// ID string fragments, fragment 0 in the low 16 bits.
	localparam logic [63:0] IdChars = 64'h4F44_4E45_544E_494E;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;    // [31:0] rx_word, [33:32] rumble_mode, [39:34] zero
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;    // [31:0] tx_word

	// Local copy of the protocol state.
	shrr_pkg::stage_t shake_stage;
	logic [2:0]  shake_index;
	logic [15:0] shake_upper;
	logic [15:0] shake_lower;

	logic [31:0] pending_replies[$];
	logic [31:0] reply_due;
	int          mismatches;
	int          words_sent;
	int          quiet_cycles;
	bit          steady;

	serial_handshake_rumble_responder dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// The receiver stalls at random unless a steady stretch is running.
	always @(negedge clk) begin
		m_tready <= steady || ($urandom_range(99) >= IdlePct);
	end

	// Compare each reply word with the oldest prediction and watch for a hang.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_replies.size() == 0) begin
				$display("%0t: reply word expected none, got %h", $time, m_tdata);
				mismatches++;
			end else begin
				reply_due = pending_replies.pop_front();
				if (m_tdata !== reply_due) begin
					$display("%0t: reply word expected %h, got %h", $time, reply_due,
						m_tdata);
					mismatches++;
				end
			end
		end
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= WatchdogLimit) begin
			$display("%0t: no word moved for %0d cycles", $time, WatchdogLimit);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic clear_protocol();
		shake_stage = shrr_pkg::STAGE_SHAKE;
		shake_index = '0;
		shake_upper = '0;
		shake_lower = '0;
	endtask

	// Advance the local protocol state by one received word and queue the
	// reply it causes, if any.
	task automatic step_protocol(input logic [31:0] rx, input logic [1:0] mode);
		logic [31:0] prev;
		logic [31:0] tx;
		bit          replies;
		prev = {shake_upper, shake_lower};
		tx = '0;
		replies = 1'b1;
		case (shake_stage)
			shrr_pkg::STAGE_SHAKE: begin
				if (rx[15:0] == shrr_pkg::LowStart) begin
					tx = shrr_pkg::MagicOne;
					shake_stage = shrr_pkg::STAGE_MAGIC1;
				end else begin
					// A wrong echo of the upper half restarts the string.
					if (rx[31:16] != shake_lower) begin
						shake_index = '0;
					end
					if (shake_index <= shrr_pkg::LastFrag && rx == ~prev) begin
						shake_index = shake_index + 3'd1;
					end
					if (shake_index > shrr_pkg::LastFrag) begin
						shake_upper = shrr_pkg::StringEnd;
					end else begin
						shake_upper = IdChars[shake_index[1:0] * 16 +: 16];
					end
					shake_lower = ~rx[15:0];
					tx = {shake_upper, shake_lower};
				end
			end
			shrr_pkg::STAGE_MAGIC1: begin
				if (rx == shrr_pkg::MagicOne) begin
					tx = shrr_pkg::MagicTwo;
					shake_stage = shrr_pkg::STAGE_MAGIC2;
				end else begin
					shake_stage = shrr_pkg::STAGE_FINAL;
				end
			end
			shrr_pkg::STAGE_MAGIC2: begin
				if (rx == shrr_pkg::MagicTwo) begin
					tx = shrr_pkg::CmdStop;
					shake_stage = shrr_pkg::STAGE_RUMBLE;
				end else begin
					shake_stage = shrr_pkg::STAGE_FINAL;
				end
			end
			shrr_pkg::STAGE_RUMBLE: begin
				if (rx == shrr_pkg::WordPoll) begin
					// The undefined command code answers as stop.
					case (mode)
						shrr_pkg::MODE_START: tx = shrr_pkg::CmdStart;
						shrr_pkg::MODE_HARD:  tx = shrr_pkg::CmdHard;
						default:              tx = shrr_pkg::CmdStop;
					endcase
				end else begin
					shake_stage = shrr_pkg::STAGE_FINAL;
				end
			end
			default: begin
				clear_protocol();
				replies = 1'b0;
			end
		endcase
		if (replies) begin
			pending_replies.push_back(tx);
		end
	endtask

	// Offer one word on the s_ channel; called and left at a falling edge.
	task automatic send_word(input logic [31:0] rx, input logic [1:0] mode);
		while (!steady && $urandom_range(99) < IdlePct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'b0, mode, rx};
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		words_sent++;
		step_protocol(rx, mode);
		@(negedge clk);
	endtask

	// Handshake word that moves the string forward: the echo of the last
	// reply when it can advance, else a word that keeps the position and
	// makes the next reply echoable.
	function automatic logic [31:0] next_shake_word();
		logic [15:0] frag;
		frag = (shake_index > shrr_pkg::LastFrag) ? shrr_pkg::StringEnd :
			IdChars[shake_index[1:0] * 16 +: 16];
		if (shake_lower == ~shake_upper) begin
			return ~{shake_upper, shake_lower};
		end
		return {shake_lower, frag};
	endfunction

	// Some word other than the one the current stage wants.
	function automatic logic [31:0] wrong_word(input logic [31:0] good);
		logic [31:0] word;
		case ($urandom_range(3))
			0:       word = good ^ (32'd1 << $urandom_range(31));
			1:       word = shrr_pkg::WordPoll;
			2:       word = shrr_pkg::MagicOne;
			default: word = $urandom();
		endcase
		if (word == good) begin
			word = ~good;
		end
		return word;
	endfunction

	// Walk the ID string to its end, then send extra words past the end.
	// Noise words either keep the echoed upper half or break it.
	task automatic walk_id_string(input int extra, input int noise_pct);
		int steps;
		logic [15:0] upper;
		steps = 0;
		while (shake_stage == shrr_pkg::STAGE_SHAKE && steps < 40
				&& (shake_index <= shrr_pkg::LastFrag || extra > 0)) begin
			if (shake_index > shrr_pkg::LastFrag) begin
				extra--;
			end
			if ($urandom_range(99) < noise_pct) begin
				upper = $urandom_range(1) ? shake_lower : 16'($urandom());
				send_word({upper, 16'($urandom())}, 2'($urandom_range(3)));
			end else begin
				send_word(next_shake_word(), 2'($urandom_range(3)));
			end
			steps++;
		end
	endtask

	// One exchange: stop_at 0 ends in the handshake, 1 and 2 break the
	// first or second magic word, 3 reaches the rumble stage.
	task automatic run_session(input int stop_at, input int extra, input int polls,
			input int noise_pct);
		walk_id_string(extra, noise_pct);
		if (stop_at == 0) begin
			return;
		end
		send_word({16'($urandom()), shrr_pkg::LowStart}, 2'($urandom_range(3)));
		send_word((stop_at == 1) ? wrong_word(shrr_pkg::MagicOne) : shrr_pkg::MagicOne,
			2'($urandom_range(3)));
		if (stop_at >= 2) begin
			send_word((stop_at == 2) ? wrong_word(shrr_pkg::MagicTwo) : shrr_pkg::MagicTwo,
				2'($urandom_range(3)));
		end
		if (stop_at == 3) begin
			// The first polls go through every command code in turn.
			for (int i = 0; i < polls; i++) begin
				send_word(shrr_pkg::WordPoll, (i < 4) ? 2'(i) : 2'($urandom_range(3)));
			end
			send_word(wrong_word(shrr_pkg::WordPoll), 2'($urandom_range(3)));
		end
		// The finalize stage swallows one word, even a start request.
		if ($urandom_range(1)) begin
			send_word({16'($urandom()), shrr_pkg::LowStart}, 2'($urandom_range(3)));
		end else begin
			send_word($urandom(), 2'($urandom_range(3)));
		end
	endtask

	// All-zero and all-one words and halves while in the handshake.
	task automatic test_extreme_words();
		send_word(32'h0000_0000, shrr_pkg::MODE_STOP);
		send_word(32'hFFFF_FFFF, 2'd3);
		send_word(32'h0000_FFFF, shrr_pkg::MODE_START);
		send_word(32'hFFFF_0000, shrr_pkg::MODE_HARD);
	endtask

	// Whole string, echoes past its end, magic words, every command code,
	// a broken poll and the finalize word.
	task automatic test_full_session();
		run_session(3, 2, 4, 0);
	endtask

	// Start request at index zero, then a broken second magic word.
	task automatic test_broken_magic();
		send_word({16'hFFFF, shrr_pkg::LowStart}, 2'd3);
		send_word(shrr_pkg::MagicOne, shrr_pkg::MODE_STOP);
		send_word(shrr_pkg::MagicOne, shrr_pkg::MODE_START);
		send_word(32'h0000_0000, shrr_pkg::MODE_HARD);
	endtask

	task automatic test_random_sessions(input int count);
		int stop_at;
		int target;
		target = words_sent + count;
		while (words_sent < target) begin
			stop_at = $urandom_range(9);
			if (stop_at > 3) begin
				stop_at = 3;
			end
			run_session(stop_at, $urandom_range(3), $urandom_range(12),
				$urandom_range(2) == 0 ? 0 : $urandom_range(20));
		end
	endtask

	// Same sessions with both channels running without a gap.
	task automatic test_back_to_back(input int count);
		steady = 1'b1;
		test_random_sessions(count);
		steady = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		steady = 1'b0;
		mismatches = 0;
		words_sent = 0;
		quiet_cycles = 0;
		clear_protocol();
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		test_extreme_words();
		test_full_session();
		test_broken_magic();
		test_random_sessions(300);
		test_back_to_back(150);
		test_random_sessions(300);

		s_tvalid <= 1'b0;
		while (pending_replies.size() != 0) begin
			@(posedge clk);
		end
		repeat (DrainCycles) @(posedge clk);
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
